// File: design/imsi_pkg.sv
package imsi_pkg;

	// Fixed widths of the element and result fields.
	localparam int unsigned BYTE_W    = 8;
	localparam int unsigned LEN_W     = 16;
	localparam int unsigned POS_W     = 4;
	localparam int unsigned COUNT_W   = 5;
	localparam int unsigned DCOUNT_W  = 4;
	localparam int unsigned NIBBLE_W  = 4;
	localparam int unsigned SLOT_COUNT = 15;
	localparam int unsigned DIGITS_W  = SLOT_COUNT * NIBBLE_W;

	// Byte positions and codes inside the element.
	localparam logic [POS_W-1:0]    POS_TYPE      = 4'd0;
	localparam logic [POS_W-1:0]    POS_LEN_HI    = 4'd1;
	localparam logic [POS_W-1:0]    POS_LEN_LO    = 4'd2;
	localparam logic [POS_W-1:0]    POS_SPARE     = 4'd3;
	localparam logic [POS_W-1:0]    POS_SAT       = 4'd15;
	localparam logic [BYTE_W-1:0]   IE_TYPE_IMSI  = 8'd1;
	localparam logic [NIBBLE_W-1:0] DIGIT_MAX     = 4'b1001;
	localparam logic [NIBBLE_W-1:0] FILLER        = 4'b1111;

	// One input item.
	typedef struct packed {
		logic [BYTE_W-1:0] ie_byte;
		logic              final_byte;
	} byte_item_t;

	// One result item.
	typedef struct packed {
		logic                accepted;
		logic [DCOUNT_W-1:0] digit_count;
		logic [DIGITS_W-1:0] imsi_digits;
	} result_item_t;

	// Per-element parsing state.
	typedef struct packed {
		logic [POS_W-1:0]    pos;
		logic [LEN_W-1:0]    len;
		logic                err;
		logic [DIGITS_W-1:0] digits;
		logic [COUNT_W-1:0]  count;
	} elem_state_t;

endpackage

// File: design/imsi_chan_if.sv
// Valid/ready channel carrying one item of the given payload type.
interface imsi_chan_if #(parameter type item_t = logic);
	logic  valid;
	logic  ready;
	item_t payload;

	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface

// File: design/imsi_step.sv
module imsi_step #(
	parameter int unsigned MAX_DIGITS = 15
) (
	input  imsi_pkg::elem_state_t         cur,
	input  logic [imsi_pkg::BYTE_W-1:0]   ie_byte,
	input  logic                          final_byte,
	output imsi_pkg::elem_state_t         nxt,
	output logic [imsi_pkg::DIGITS_W-1:0] upd_digits,
	output logic [imsi_pkg::COUNT_W-1:0]  upd_count,
	output logic                          ok
);

	localparam logic [imsi_pkg::COUNT_W-1:0] MAX_C = imsi_pkg::COUNT_W'(MAX_DIGITS);

	logic [imsi_pkg::NIBBLE_W-1:0] lo;
	logic [imsi_pkg::NIBBLE_W-1:0] hi;
	logic                          push_hi;
	logic                          lo_bad;
	logic                          hi_bad;
	logic [imsi_pkg::COUNT_W-1:0]  count_lo;
	logic [imsi_pkg::COUNT_W-1:0]  count_hi;
	logic [imsi_pkg::DIGITS_W-1:0] digits_lo;
	logic [imsi_pkg::DIGITS_W-1:0] digits_hi;
	logic                          payload_byte;
	imsi_pkg::elem_state_t         upd;

	assign lo = ie_byte[imsi_pkg::NIBBLE_W-1:0];
	assign hi = ie_byte[imsi_pkg::BYTE_W-1:imsi_pkg::NIBBLE_W];
	assign payload_byte = (cur.pos > imsi_pkg::POS_SPARE);
	// The filler in the last nibble of the element is dropped.
	assign push_hi = !(final_byte && (hi == imsi_pkg::FILLER));

	// Low nibble goes first, then the high nibble, each into the next free slot.
	always_comb begin
		lo_bad    = (lo > imsi_pkg::DIGIT_MAX) || (cur.count >= MAX_C);
		digits_lo = cur.digits;
		count_lo  = cur.count;
		if (!lo_bad) begin
			for (int i = 0; i < imsi_pkg::SLOT_COUNT; i++) begin
				if (cur.count == imsi_pkg::COUNT_W'(i)) begin
					digits_lo[i*imsi_pkg::NIBBLE_W +: imsi_pkg::NIBBLE_W] = lo;
				end
			end
			count_lo = cur.count + 1'b1;
		end

		hi_bad    = push_hi && ((hi > imsi_pkg::DIGIT_MAX) || (count_lo >= MAX_C));
		digits_hi = digits_lo;
		count_hi  = count_lo;
		if (push_hi && !hi_bad) begin
			for (int i = 0; i < imsi_pkg::SLOT_COUNT; i++) begin
				if (count_lo == imsi_pkg::COUNT_W'(i)) begin
					digits_hi[i*imsi_pkg::NIBBLE_W +: imsi_pkg::NIBBLE_W] = hi;
				end
			end
			count_hi = count_lo + 1'b1;
		end
	end

	// Header fields by position, payload digits from the fifth byte on.
	always_comb begin
		upd = cur;
		case (cur.pos)
			imsi_pkg::POS_TYPE: begin
				if (ie_byte != imsi_pkg::IE_TYPE_IMSI) begin
					upd.err = 1'b1;
				end
			end
			imsi_pkg::POS_LEN_HI: begin
				upd.len = {ie_byte, imsi_pkg::BYTE_W'(0)};
			end
			imsi_pkg::POS_LEN_LO: begin
				upd.len = {cur.len[imsi_pkg::LEN_W-1:imsi_pkg::BYTE_W], ie_byte};
			end
			default: begin
				if (payload_byte) begin
					upd.err    = cur.err || lo_bad || hi_bad;
					upd.digits = digits_hi;
					upd.count  = count_hi;
				end
			end
		endcase
		if (cur.pos != imsi_pkg::POS_SAT) begin
			upd.pos = cur.pos + 1'b1;
		end
	end

	// Digits and count of the element after this byte, before any clearing.
	assign upd_digits = upd.digits;
	assign upd_count  = upd.count;

	// Verdict on the final byte, judged on the state after this byte.
	always_comb begin
		ok = !upd.err && (cur.pos >= imsi_pkg::POS_SPARE) && (cur.pos != imsi_pkg::POS_SAT)
			&& (upd.len == imsi_pkg::LEN_W'(cur.pos - imsi_pkg::POS_SPARE))
			&& (upd.count != '0) && (upd.count <= MAX_C);
		nxt = final_byte ? '0 : upd;
	end

endmodule

// File: design/imsi_ie_tbcd_parser.sv
// Channel   Dir  Payload                                    Accepted when
// byte_ch   in   ie_byte[7:0], final_byte                   valid && ready
// result_ch out  accepted, digit_count[3:0], imsi_digits    valid && ready
//
// One byte per cycle unless a final byte is held: a byte is taken into the
// input register, then folded into the element state; a final byte also loads
// the result register as it is folded, which makes its result valid.
// Reset clears the element state and the stored IMSI (the stored count reads zero).
// A pending result stalls only a final byte waiting in the input register;
// other bytes keep flowing.
module imsi_ie_tbcd_parser #(
	parameter int unsigned MAX_DIGITS = 15
) (
	input logic      clk,
	input logic      arst_n,
	imsi_chan_if.sink   byte_ch,
	imsi_chan_if.source result_ch
);

	logic                          valid_s1;
	imsi_pkg::byte_item_t          item_s1;
	imsi_pkg::elem_state_t         elem_q;
	imsi_pkg::elem_state_t         elem_nxt;
	logic [imsi_pkg::DIGITS_W-1:0] upd_digits;
	logic [imsi_pkg::COUNT_W-1:0]  upd_count;
	logic                          ok;
	logic                          advance;
	logic                          byte_take;
	logic [imsi_pkg::DIGITS_W-1:0] stored_digits_q;
	logic [imsi_pkg::DCOUNT_W-1:0] stored_count_q;
	logic                          out_valid_q;
	imsi_pkg::result_item_t        out_q;

	// The byte in the input register moves on unless it is a final byte
	// and the result register is still full.
	assign advance   = valid_s1 && (!item_s1.final_byte || !out_valid_q || result_ch.ready);
	assign byte_ch.ready = !valid_s1 || advance;
	assign byte_take = byte_ch.valid && byte_ch.ready;

	assign result_ch.valid   = out_valid_q;
	assign result_ch.payload = out_q;

	imsi_step #(.MAX_DIGITS(MAX_DIGITS)) u_step (
		.cur        (elem_q),
		.ie_byte    (item_s1.ie_byte),
		.final_byte (item_s1.final_byte),
		.nxt        (elem_nxt),
		.upd_digits (upd_digits),
		.upd_count  (upd_count),
		.ok         (ok)
	);

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_take) begin
			item_s1 <= byte_ch.payload;
		end
	end

	// Element state and stored IMSI.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			elem_q          <= '0;
			stored_digits_q <= '0;
			stored_count_q  <= '0;
		end else if (advance) begin
			elem_q <= elem_nxt;
			if (item_s1.final_byte && ok) begin
				stored_digits_q <= upd_digits;
				stored_count_q  <= imsi_pkg::DCOUNT_W'(upd_count);
			end
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && item_s1.final_byte) begin
			out_valid_q <= 1'b1;
		end else if (result_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && item_s1.final_byte) begin
			out_q.accepted    <= ok;
			out_q.digit_count <= ok ? imsi_pkg::DCOUNT_W'(upd_count) : stored_count_q;
			out_q.imsi_digits <= ok ? upd_digits : stored_digits_q;
		end
	end

	// A held input byte blocks the next one.
	a_hold_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |-> !byte_ch.ready)
		else $error("input register overwritten while holding a byte");

	// A pending result is never overwritten.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !result_ch.ready |-> !(advance && item_s1.final_byte))
		else $error("result register overwritten while pending");

	// A final byte restarts the element.
	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		advance && item_s1.final_byte |=> elem_q.pos == imsi_pkg::POS_TYPE)
		else $error("element state not cleared after final byte");

	// The stored IMSI changes only on a final byte.
	a_stored_stable: assert property (@(posedge clk) disable iff (!arst_n)
		!(advance && item_s1.final_byte) |=> $stable(stored_digits_q) && $stable(stored_count_q))
		else $error("stored IMSI changed without a final byte");

endmodule
